// ----- rtl/lobm_pkg.sv -----
package lobm_pkg;

  localparam int BOOK_SLOTS_DEF = 64;
  localparam int MAX_TRADES = 64;
  localparam int TW = $clog2(MAX_TRADES + 1);
  localparam int TAW = $clog2(MAX_TRADES);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_EOD    = 2'd3
  } op_t;

  localparam logic [2:0] KIND_GTC = 3'd0;
  localparam logic [2:0] KIND_FAK = 3'd1;
  localparam logic [2:0] KIND_FOK = 3'd2;
  localparam logic [2:0] KIND_MKT = 3'd3;
  localparam logic [2:0] KIND_GFD = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_KILL    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic        side;
    logic [2:0]  kind;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] arrival;
  } slot_t;

  typedef struct packed {
    logic [31:0] id1;
    logic [31:0] p1;
    logic [31:0] id2;
    logic [31:0] p2;
    logic [31:0] qty;
  } trade_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLR, DP_LOAD, DP_SCAN_INIT, DP_SCAN, DP_REMOVE, DP_TRADE,
    DP_REST, DP_OUT_STAT, DP_OUT_RD, DP_OUT_LD, DP_OUT_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       scan_b;
    logic       set_status;
    logic [2:0] status;
  } cmd_t;

  typedef struct packed {
    logic       idx_done;
    logic       scan_done;
    op_t        op;
    logic [2:0] kind;
    logic       qty_zero;
    logic       found;
    logic       free_found;
    logic       best_found;
    logic       best_cross;
    logic       fok_ok;
    logic       rem_zero;
    logic       n_zero;
    logic       n_full;
  } sts_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SA_INIT, S_SA, S_AFTER_A, S_REMOVE, S_SB_INIT, S_SB,
    S_CHECK, S_MATCH, S_TRADE, S_LOOP, S_FINISH, S_REST, S_OUT_PREP,
    S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

endpackage

// ----- rtl/lobm_if.sv -----
interface lobm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] order_id;
  logic        side;
  logic [2:0]  order_kind;
  logic signed [31:0] limit_price;
  logic [31:0] order_quantity;
  modport source (output valid, op, order_id, side, order_kind, limit_price,
                  order_quantity, input ready);
  modport sink (input valid, op, order_id, side, order_kind, limit_price,
                order_quantity, output ready);
endinterface

interface lobm_out_if;
  logic        valid;
  logic        ready;
  logic        trade_valid;
  logic [31:0] first_order_id;
  logic signed [31:0] first_price;
  logic [31:0] second_order_id;
  logic signed [31:0] second_price;
  logic [31:0] trade_quantity;
  logic [2:0]  status;
  logic [6:0]  resting_count;
  logic        last;
  modport source (output valid, trade_valid, first_order_id, first_price,
                  second_order_id, second_price, trade_quantity, status,
                  resting_count, last, input ready);
  modport sink (input valid, trade_valid, first_order_id, first_price,
                second_order_id, second_price, trade_quantity, status,
                resting_count, last, output ready);
endinterface

// ----- rtl/lobm_ram.sv -----
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/lobm_ctrl.sv -----
module lobm_ctrl
  import lobm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic out_last,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   rests;

  assign rests = (sts.kind == KIND_GTC) || (sts.kind == KIND_GFD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd = '{op: DP_NOP, scan_b: 1'b0, set_status: 1'b0, status: ST_OK};
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLR;
        if (sts.idx_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = DP_LOAD;
          state_nxt = S_SA_INIT;
        end
      end
      S_SA_INIT: begin
        cmd.op = DP_SCAN_INIT;
        state_nxt = S_SA;
      end
      S_SA: begin
        cmd.op = DP_SCAN;
        if (sts.scan_done) state_nxt = S_AFTER_A;
      end
      S_AFTER_A: begin
        first_nxt = 1'b1;
        case (sts.op)
          OP_EOD: state_nxt = S_OUT_PREP;
          OP_ADD: begin
            if (sts.found) begin
              cmd.set_status = 1'b1;
              cmd.status = ST_DUP;
              state_nxt = S_OUT_PREP;
            end else if (sts.qty_zero) state_nxt = S_OUT_PREP;
            else state_nxt = S_SB_INIT;
          end
          default: begin
            if (sts.found) state_nxt = S_REMOVE;
            else begin
              cmd.set_status = 1'b1;
              cmd.status = ST_UNKNOWN;
              state_nxt = S_OUT_PREP;
            end
          end
        endcase
      end
      S_REMOVE: begin
        cmd.op = DP_REMOVE;
        if (sts.op == OP_MODIFY && !sts.qty_zero) state_nxt = S_SB_INIT;
        else state_nxt = S_OUT_PREP;
      end
      S_SB_INIT: begin
        cmd.op = DP_SCAN_INIT;
        cmd.scan_b = 1'b1;
        state_nxt = S_SB;
      end
      S_SB: begin
        cmd.op = DP_SCAN;
        if (sts.scan_done) state_nxt = first_r ? S_CHECK : S_MATCH;
      end
      S_CHECK: begin
        first_nxt = 1'b0;
        state_nxt = S_MATCH;
        if ((sts.kind == KIND_FAK && !(sts.best_found && sts.best_cross)) ||
            (sts.kind == KIND_FOK && !sts.fok_ok)) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_KILL;
          state_nxt = S_OUT_PREP;
        end else if (rests && !sts.free_found) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_FULL;
          state_nxt = S_OUT_PREP;
        end
      end
      S_MATCH: begin
        if (sts.best_found && (sts.kind == KIND_MKT || sts.best_cross))
          state_nxt = S_TRADE;
        else state_nxt = S_FINISH;
      end
      S_TRADE: begin
        cmd.op = DP_TRADE;
        state_nxt = S_LOOP;
      end
      S_LOOP: begin
        if (sts.rem_zero || sts.n_full) state_nxt = S_FINISH;
        else state_nxt = S_SB_INIT;
      end
      S_FINISH: begin
        if (sts.kind == KIND_MKT && sts.n_zero) begin
          cmd.set_status = 1'b1;
          cmd.status = ST_KILL;
        end
        if (rests && !sts.rem_zero) state_nxt = S_REST;
        else state_nxt = S_OUT_PREP;
      end
      S_REST: begin
        cmd.op = DP_REST;
        state_nxt = S_OUT_PREP;
      end
      S_OUT_PREP: begin
        if (sts.n_zero) begin
          cmd.op = DP_OUT_STAT;
          state_nxt = S_OUT_WAIT;
        end else state_nxt = S_OUT_RD;
      end
      S_OUT_RD: begin
        cmd.op = DP_OUT_RD;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd.op = DP_OUT_LD;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (out_last) state_nxt = S_IDLE;
          else begin
            cmd.op = DP_OUT_NEXT;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/lobm_datapath.sv -----
module lobm_datapath
  import lobm_pkg::*;
#(
  parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic [2:0]  in_order_kind,
  input  logic [31:0] in_limit_price,
  input  logic [31:0] in_order_quantity,
  output logic        out_trade_valid,
  output logic [31:0] out_first_order_id,
  output logic [31:0] out_first_price,
  output logic [31:0] out_second_order_id,
  output logic [31:0] out_second_price,
  output logic [31:0] out_trade_quantity,
  output logic [2:0]  out_status,
  output logic [6:0]  out_resting_count,
  output logic        out_last
);
  localparam int IW = $clog2(BOOK_SLOTS);
  localparam int CW = $clog2(BOOK_SLOTS + 1);
  localparam int SW = $bits(slot_t);
  localparam int XW = $bits(trade_t);

  logic [IW:0]    idx_r;
  logic           pv_r, mode_b_r;
  logic [IW-1:0]  pidx_r, fidx_r, freeidx_r, bidx_r;
  op_t            op_r;
  logic [31:0]    id_r, price_r, qty_r, rem_r, arr_r, bage_r;
  logic           side_r;
  logic [2:0]     kind_r, status_r;
  logic           found_r, free_r, best_r;
  slot_t          brec_r;
  logic [32:0]    sum_r;
  logic [CW-1:0]  cnt_r;
  logic [TW-1:0]  n_r, k_r;

  logic           swe;
  logic [IW-1:0]  swaddr;
  slot_t          swdata, rec;
  logic [SW-1:0]  srd;
  trade_t         twdata, trd;
  logic [XW-1:0]  trd_raw;

  logic        opp, better, cross_rec, best_cross, idx_end;
  logic [31:0] age, q, newrem;
  logic [33:0] sum_add;
  logic [CW+6:0] cnt_ext;

  lobm_ram #(.WIDTH(SW), .DEPTH(BOOK_SLOTS)) u_slots (
    .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
    .raddr(idx_r[IW-1:0]), .rdata(srd));

  lobm_ram #(.WIDTH(XW), .DEPTH(MAX_TRADES)) u_trades (
    .clk(clk), .we(cmd.op == DP_TRADE), .waddr(n_r[TAW-1:0]), .wdata(twdata),
    .raddr(k_r[TAW-1:0]), .rdata(trd_raw));

  assign rec = slot_t'(srd);
  assign trd = trade_t'(trd_raw);
  assign opp = ~side_r;
  assign age = arr_r - rec.arrival;
  assign idx_end = (idx_r == (IW+1)'(BOOK_SLOTS));
  assign cross_rec = side_r ? ($signed(price_r) <= $signed(rec.price))
                            : ($signed(price_r) >= $signed(rec.price));
  assign best_cross = side_r ? ($signed(price_r) <= $signed(brec_r.price))
                             : ($signed(price_r) >= $signed(brec_r.price));
  always_comb begin
    if (!best_r) better = 1'b1;
    else if (rec.price != brec_r.price)
      better = opp ? ($signed(rec.price) < $signed(brec_r.price))
                   : ($signed(rec.price) > $signed(brec_r.price));
    else better = age > bage_r;
  end
  assign q = (rem_r < brec_r.remaining) ? rem_r : brec_r.remaining;
  assign newrem = brec_r.remaining - q;
  assign sum_add = {1'b0, sum_r} + {2'b00, rec.remaining};
  assign cnt_ext = {7'd0, cnt_r};

  always_comb begin
    if (kind_r == KIND_MKT || !side_r)
      twdata = '{id1: id_r, p1: price_r, id2: brec_r.id, p2: brec_r.price, qty: q};
    else
      twdata = '{id1: brec_r.id, p1: brec_r.price, id2: id_r, p2: price_r, qty: q};
  end

  always_comb begin
    swe = 1'b0;
    swaddr = pidx_r;
    swdata = '0;
    case (cmd.op)
      DP_CLR: begin
        swe = 1'b1;
        swaddr = idx_r[IW-1:0];
      end
      DP_SCAN: begin
        // end of day: drop good-for-day orders as the scan passes them
        if (pv_r && !mode_b_r && op_r == OP_EOD && rec.valid && rec.kind == KIND_GFD) begin
          swe = 1'b1;
          swdata = rec;
          swdata.valid = 1'b0;
        end
      end
      DP_REMOVE: begin
        swe = 1'b1;
        swaddr = fidx_r;
      end
      DP_TRADE: begin
        swe = 1'b1;
        swaddr = bidx_r;
        swdata = brec_r;
        swdata.remaining = newrem;
        swdata.valid = (newrem != 32'd0);
      end
      DP_REST: begin
        swe = 1'b1;
        swaddr = freeidx_r;
        swdata = '{valid: 1'b1, id: id_r, side: side_r, kind: kind_r, price: price_r,
                   remaining: rem_r, arrival: arr_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      pv_r <= 1'b0;
      cnt_r <= '0;
      arr_r <= '0;
      n_r <= '0;
      k_r <= '0;
      status_r <= ST_OK;
    end else begin
      if (cmd.set_status) status_r <= cmd.status;
      case (cmd.op)
        DP_CLR: idx_r <= idx_r + 1'b1;
        DP_LOAD: begin
          op_r <= op_t'(in_op);
          id_r <= in_order_id;
          side_r <= in_side;
          price_r <= in_limit_price;
          qty_r <= in_order_quantity;
          rem_r <= in_order_quantity;
          if (op_t'(in_op) == OP_MODIFY || in_order_kind > KIND_GFD) kind_r <= KIND_GTC;
          else kind_r <= in_order_kind;
          n_r <= '0;
          k_r <= '0;
          status_r <= ST_OK;
          // the free slot is taken from the first match scan only
          free_r <= 1'b0;
        end
        DP_SCAN_INIT: begin
          idx_r <= '0;
          pv_r <= 1'b0;
          mode_b_r <= cmd.scan_b;
          if (cmd.scan_b) begin
            best_r <= 1'b0;
            sum_r <= '0;
          end else found_r <= 1'b0;
        end
        DP_SCAN: begin
          if (!idx_end) idx_r <= idx_r + 1'b1;
          pv_r <= !idx_end;
          pidx_r <= idx_r[IW-1:0];
          if (pv_r && rec.valid) begin
            if (!mode_b_r) begin
              if (rec.id == id_r) begin
                found_r <= 1'b1;
                fidx_r <= pidx_r;
              end
              if (op_r == OP_EOD && rec.kind == KIND_GFD) cnt_r <= cnt_r - 1'b1;
            end else if (rec.side == opp) begin
              if (better) begin
                best_r <= 1'b1;
                bidx_r <= pidx_r;
                brec_r <= rec;
                bage_r <= age;
              end
              if (cross_rec) sum_r <= sum_add[33] ? '1 : sum_add[32:0];
            end
          end else if (pv_r && mode_b_r && !free_r) begin
            free_r <= 1'b1;
            freeidx_r <= pidx_r;
          end
        end
        DP_REMOVE: cnt_r <= cnt_r - 1'b1;
        DP_TRADE: begin
          rem_r <= rem_r - q;
          n_r <= n_r + 1'b1;
          if (newrem == 32'd0) cnt_r <= cnt_r - 1'b1;
        end
        DP_REST: begin
          arr_r <= arr_r + 32'd1;
          cnt_r <= cnt_r + 1'b1;
        end
        DP_OUT_STAT: begin
          out_trade_valid <= 1'b0;
          out_first_order_id <= '0;
          out_first_price <= '0;
          out_second_order_id <= '0;
          out_second_price <= '0;
          out_trade_quantity <= '0;
          out_status <= status_r;
          out_resting_count <= cnt_ext[6:0];
          out_last <= 1'b1;
        end
        DP_OUT_LD: begin
          out_trade_valid <= 1'b1;
          out_first_order_id <= trd.id1;
          out_first_price <= trd.p1;
          out_second_order_id <= trd.id2;
          out_second_price <= trd.p2;
          out_trade_quantity <= trd.qty;
          out_status <= ST_OK;
          out_resting_count <= cnt_ext[6:0];
          out_last <= (k_r == n_r - 1'b1);
        end
        DP_OUT_NEXT: k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  assign sts = '{idx_done: idx_end, scan_done: idx_end && !pv_r, op: op_r, kind: kind_r,
                 qty_zero: qty_r == 32'd0, found: found_r, free_found: free_r,
                 best_found: best_r, best_cross: best_cross,
                 fok_ok: sum_r >= {1'b0, qty_r}, rem_zero: rem_r == 32'd0,
                 n_zero: n_r == '0, n_full: n_r == TW'(MAX_TRADES)};
endmodule

// ----- rtl/limit_order_book_matcher.sv -----
// Price-time matching engine over a book of BOOK_SLOTS resting orders held in one
// slot RAM. After reset a clearing pass empties the book before the first request is
// taken. A request is handled one at a time: a lookup scan, and for add or modify a
// new match scan ahead of each trade (best order, free slot and fill-or-kill depth
// are found by the scan, one slot per cycle through the RAM read port), then the
// trade words (or one status word) on the output. Trades are staged in a 64-entry
// buffer so every word carries the final resting count.
module limit_order_book_matcher
  import lobm_pkg::*;
#(
  parameter int BOOK_SLOTS = BOOK_SLOTS_DEF
) (
  input logic clk,
  input logic rst_n,
  lobm_in_if.sink    in_if,
  lobm_out_if.source out_if
);
  cmd_t cmd;
  sts_t sts;

  lobm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_last(out_if.last),
    .sts(sts), .cmd(cmd));

  lobm_datapath #(.BOOK_SLOTS(BOOK_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_if.op), .in_order_id(in_if.order_id), .in_side(in_if.side),
    .in_order_kind(in_if.order_kind), .in_limit_price(in_if.limit_price),
    .in_order_quantity(in_if.order_quantity),
    .out_trade_valid(out_if.trade_valid), .out_first_order_id(out_if.first_order_id),
    .out_first_price(out_if.first_price), .out_second_order_id(out_if.second_order_id),
    .out_second_price(out_if.second_price), .out_trade_quantity(out_if.trade_quantity),
    .out_status(out_if.status), .out_resting_count(out_if.resting_count),
    .out_last(out_if.last));

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid)) else $error("input taken while output pending");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && out_if.last |=> !out_if.valid)
    else $error("output word after last");
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.trade_valid |-> out_if.last)
    else $error("status word not last");
`endif
endmodule
